### hdl/fif_pkg.sv
package fif_pkg;

   localparam int DEPTH    = 16;
   localparam int HANDLE_W = 32;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int KIND_W   = 2;
   localparam int RSP_W    = ((HANDLE_W + CNT_W + 7) / 8) * 8;

   typedef enum logic [KIND_W-1:0] {
      REQ_ENQ = 2'd0,
      REQ_DEQ = 2'd1,
      REQ_DEL = 2'd2
   } req_kind_type;

   // per-request control broadcast to every cell, already qualified
   typedef struct packed {
      logic                enq;     // accepted enqueue that will succeed
      logic                deq;     // accepted dequeue on a non-empty queue
      logic                del;     // accepted delete with a nonzero handle
      logic [HANDLE_W-1:0] handle;
      logic [CNT_W-1:0]    count;
   } cell_ctrl_type;

endpackage

### hdl/fif_cell.sv
module fif_cell (
   input  logic                           clock,
   input  fif_pkg::cell_ctrl_type         ctrl,
   input  logic [fif_pkg::IDX_W-1:0]      idx,
   input  logic [fif_pkg::HANDLE_W-1:0]   next_entry,
   input  logic                           hit_in,
   output logic                           hit_out,
   output logic [fif_pkg::HANDLE_W-1:0]   entry
);

   logic [fif_pkg::HANDLE_W-1:0] entry_ff;
   logic [fif_pkg::HANDLE_W-1:0] entry_in;
   logic [fif_pkg::CNT_W-1:0]    pos;
   logic                         held;
   logic                         match;

   assign pos     = fif_pkg::CNT_W'(idx);
   assign held    = pos < ctrl.count;
   assign match   = ctrl.del && held && (entry_ff == ctrl.handle);
   // set from the first matching cell toward the tail
   assign hit_out = hit_in | match;
   assign entry   = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.deq || (ctrl.del && hit_out)) begin
         entry_in = next_entry;
      end else if (ctrl.enq && (pos == ctrl.count)) begin
         entry_in = ctrl.handle;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### hdl/fifo_with_delete_by_handle.sv
// channel  direction  tdata                           tuser
// req_     in         handle[31:0]                    req_type[1:0]
// rsp_     out        out_handle[31:0], length[36:32]  status[0]
// one request per cycle: compare, compaction and append finish in the cell row in the
// accepting cycle, and the result sits in the output register the cycle after.
// req_tready follows only the output register and rsp_tready, so a request is taken
// while a result is being handed off; a stalled result holds the request side.
// reset empties the queue at once; no clearing pass over the cells.
module fifo_with_delete_by_handle (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [fif_pkg::HANDLE_W-1:0]    req_tdata,   // handle
   input  logic [fif_pkg::KIND_W-1:0]      req_tuser,   // req_type
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [fif_pkg::RSP_W-1:0]       rsp_tdata,   // out_handle, length
   output logic                            rsp_tuser    // status
);

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [fif_pkg::RSP_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                          rsp_status_ff, rsp_status_in;
   logic [fif_pkg::CNT_W-1:0]     count_ff, count_in;
   logic                          fire;
   logic                          handle_ok;
   logic                          status;
   logic [fif_pkg::HANDLE_W-1:0]  out_handle;
   fif_pkg::cell_ctrl_type        ctrl;
   logic [fif_pkg::HANDLE_W-1:0]  entries [fif_pkg::DEPTH];
   logic [fif_pkg::DEPTH:0]       hits;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign fire       = req_tvalid && req_tready;
   assign handle_ok  = req_tdata != '0;
   assign hits[0]    = 1'b0;

   always_comb begin
      ctrl        = '0;
      ctrl.handle = req_tdata;
      ctrl.count  = count_ff;
      unique case (req_tuser)
         fif_pkg::REQ_ENQ: ctrl.enq = fire && handle_ok &&
                                      (count_ff < fif_pkg::CNT_W'(fif_pkg::DEPTH));
         fif_pkg::REQ_DEQ: ctrl.deq = fire && (count_ff != '0);
         fif_pkg::REQ_DEL: ctrl.del = fire && handle_ok;
         default: ;
      endcase
   end

   for (genvar i = 0; i < fif_pkg::DEPTH; i++) begin : g_cell
      logic [fif_pkg::HANDLE_W-1:0] nxt;
      if (i == fif_pkg::DEPTH - 1) begin : g_tail
         assign nxt = entries[i];
      end else begin : g_mid
         assign nxt = entries[i+1];
      end
      fif_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .idx        (fif_pkg::IDX_W'(i)),
         .next_entry (nxt),
         .hit_in     (hits[i]),
         .hit_out    (hits[i+1]),
         .entry      (entries[i])
      );
   end

   always_comb begin
      status     = 1'b1;
      out_handle = '0;
      count_in   = count_ff;
      if (ctrl.enq) begin
         status   = 1'b0;
         count_in = count_ff + 1'b1;
      end else if (ctrl.deq) begin
         status     = 1'b0;
         out_handle = entries[0];
         count_in   = count_ff - 1'b1;
      end else if (ctrl.del && hits[fif_pkg::DEPTH]) begin
         status   = 1'b0;
         count_in = count_ff - 1'b1;
      end

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      if (fire) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = fif_pkg::RSP_W'({count_in, out_handle});
         rsp_status_in = status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

### hdl/fif_checker.sv
module fif_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_tready,
   input  logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic [fif_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                         rsp_tuser
);

   // a stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_len_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[fif_pkg::HANDLE_W +: fif_pkg::CNT_W]
                     <= fif_pkg::CNT_W'(fif_pkg::DEPTH))
      else $error("length above depth");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[fif_pkg::HANDLE_W-1:0] == '0)
      else $error("error result carries a handle");

   // every accepted request shows up as a result the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request gave no result");

endmodule

bind fifo_with_delete_by_handle fif_checker u_fif_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
